/* src/dts_pkg.sv */
// Shared types, constants and lookup functions of the DFA token scanner.
package dts_pkg;

  localparam int WORD_CHARS_DEF = 8;
  localparam int KW_COUNT       = 17;
  localparam int KW_MAX_LEN     = 7;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  // Token kinds
  localparam logic [5:0] TK_IDENT  = 6'd0;
  localparam logic [5:0] TK_NUM    = 6'd1;
  localparam logic [5:0] TK_STR    = 6'd2;
  localparam logic [5:0] TK_LISTOP = 6'd3;
  localparam logic [5:0] TK_PLUS   = 6'd4;
  localparam logic [5:0] TK_MINUS  = 6'd5;
  localparam logic [5:0] TK_DIV    = 6'd6;
  localparam logic [5:0] TK_MULT   = 6'd7;
  localparam logic [5:0] TK_EQ     = 6'd8;
  localparam logic [5:0] TK_GT     = 6'd9;
  localparam logic [5:0] TK_GTE    = 6'd10;
  localparam logic [5:0] TK_LT     = 6'd11;
  localparam logic [5:0] TK_LTE    = 6'd12;
  localparam logic [5:0] TK_LP     = 6'd13;
  localparam logic [5:0] TK_RP     = 6'd14;
  localparam logic [5:0] TK_SQ     = 6'd15;
  localparam logic [5:0] TK_ERR    = 6'd16;
  localparam logic [5:0] TK_KW     = 6'd17;
  localparam logic [5:0] TK_EOF    = 6'd34;

  // Character classes
  localparam logic [4:0] CL_WS     = 5'd0;
  localparam logic [4:0] CL_LETTER = 5'd1;
  localparam logic [4:0] CL_C      = 5'd2;
  localparam logic [4:0] CL_A      = 5'd3;
  localparam logic [4:0] CL_D      = 5'd4;
  localparam logic [4:0] CL_R      = 5'd5;
  localparam logic [4:0] CL_PLUS   = 5'd6;
  localparam logic [4:0] CL_MINUS  = 5'd7;
  localparam logic [4:0] CL_DOT    = 5'd8;
  localparam logic [4:0] CL_SLASH  = 5'd9;
  localparam logic [4:0] CL_DIGIT  = 5'd10;
  localparam logic [4:0] CL_STAR   = 5'd11;
  localparam logic [4:0] CL_DQUOTE = 5'd12;
  localparam logic [4:0] CL_SQUOTE = 5'd13;
  localparam logic [4:0] CL_LP     = 5'd14;
  localparam logic [4:0] CL_RP     = 5'd15;
  localparam logic [4:0] CL_LT     = 5'd16;
  localparam logic [4:0] CL_GT     = 5'd17;
  localparam logic [4:0] CL_EQ     = 5'd18;
  localparam logic [4:0] CL_UNDER  = 5'd19;
  localparam logic [4:0] CL_OTHER  = 5'd20;

  // Scanner states
  localparam logic [4:0] ST_ERR   = 5'd0;
  localparam logic [4:0] ST_START = 5'd1;
  localparam logic [4:0] ST_PLUS  = 5'd2;
  localparam logic [4:0] ST_MINUS = 5'd3;
  localparam logic [4:0] ST_INT   = 5'd4;
  localparam logic [4:0] ST_DOT   = 5'd5;
  localparam logic [4:0] ST_FRAC  = 5'd6;
  localparam logic [4:0] ST_SLASH = 5'd7;
  localparam logic [4:0] ST_RAT   = 5'd8;
  localparam logic [4:0] ST_WORD  = 5'd9;
  localparam logic [4:0] ST_STR   = 5'd10;
  localparam logic [4:0] ST_C     = 5'd11;
  localparam logic [4:0] ST_CA    = 5'd12;
  localparam logic [4:0] ST_CD    = 5'd13;
  localparam logic [4:0] ST_CAD   = 5'd14;
  localparam logic [4:0] ST_CDA   = 5'd15;
  localparam logic [4:0] ST_GT    = 5'd16;
  localparam logic [4:0] ST_LT    = 5'd17;

  localparam logic [6:0] CH_QMARK = 7'h3f;

  // Action: [7] emit then rescan, [6] emit and consume, else [4:0] next state
  typedef logic [7:0] action_t;

  typedef struct packed {
    logic [5:0] kind;
    logic       last;
  } token_t;

  typedef struct packed {
    logic [1:0] n;
    token_t     t0;
    token_t     t1;
  } push_t;

  typedef struct packed {
    logic       plain_hit;
    logic [5:0] plain_kind;
    logic       q_hit;
    logic [5:0] q_kind;
  } kw_result_t;

  typedef struct packed {
    logic [8*KW_MAX_LEN-1:0] text;
    logic [2:0]              len;
    logic                    q;
  } kw_t;

  function automatic action_t em(input logic [5:0] k);
    return {2'b01, k};
  endfunction

  function automatic action_t pb(input logic [5:0] k);
    return {2'b10, k};
  endfunction

  function automatic action_t go(input logic [4:0] s);
    return {3'b000, s};
  endfunction

  function automatic logic is_word_state(input logic [4:0] s);
    return (s == ST_WORD) || (s inside {[ST_C:ST_CDA]});
  endfunction

  function automatic logic [4:0] char_class(input logic [6:0] c);
    logic [4:0] cl;
    case (c) inside
      7'h09, 7'h0a, 7'h0d, 7'h20: cl = CL_WS;
      7'h63:         cl = CL_C;
      7'h61:         cl = CL_A;
      7'h64:         cl = CL_D;
      7'h72:         cl = CL_R;
      [7'h61:7'h7a]: cl = CL_LETTER;
      [7'h30:7'h39]: cl = CL_DIGIT;
      7'h2b:         cl = CL_PLUS;
      7'h2d:         cl = CL_MINUS;
      7'h2e:         cl = CL_DOT;
      7'h2f:         cl = CL_SLASH;
      7'h2a:         cl = CL_STAR;
      7'h22:         cl = CL_DQUOTE;
      7'h27:         cl = CL_SQUOTE;
      7'h28:         cl = CL_LP;
      7'h29:         cl = CL_RP;
      7'h3c:         cl = CL_LT;
      7'h3e:         cl = CL_GT;
      7'h3d:         cl = CL_EQ;
      7'h5f:         cl = CL_UNDER;
      default:       cl = CL_OTHER;
    endcase
    return cl;
  endfunction

  // Word-state rows: which letters move on; everything else ends the identifier
  function automatic action_t word_row(input logic [4:0] s, input logic [4:0] cl);
    action_t a;
    case (cl)
      CL_LETTER, CL_DIGIT, CL_UNDER, CL_C: a = go(ST_WORD);
      CL_A: begin
        case (s)
          ST_C:    a = go(ST_CA);
          ST_CD:   a = go(ST_CDA);
          default: a = go(ST_WORD);
        endcase
      end
      CL_D: begin
        case (s)
          ST_C, ST_CD:  a = go(ST_CD);
          ST_CA, ST_CAD: a = go(ST_CAD);
          default:      a = go(ST_WORD);
        endcase
      end
      CL_R: begin
        if (s inside {[ST_CA:ST_CDA]}) begin
          a = em(TK_LISTOP);
        end else begin
          a = go(ST_WORD);
        end
      end
      default: a = pb(TK_IDENT);
    endcase
    return a;
  endfunction

  function automatic action_t start_row(input logic [4:0] cl);
    action_t a;
    case (cl)
      CL_WS:                            a = go(ST_START);
      CL_LETTER, CL_A, CL_D, CL_R, CL_UNDER: a = go(ST_WORD);
      CL_C:      a = go(ST_C);
      CL_PLUS:   a = go(ST_PLUS);
      CL_MINUS:  a = go(ST_MINUS);
      CL_DOT:    a = go(ST_DOT);
      CL_SLASH:  a = em(TK_DIV);
      CL_DIGIT:  a = go(ST_INT);
      CL_STAR:   a = em(TK_MULT);
      CL_DQUOTE: a = go(ST_STR);
      CL_SQUOTE: a = em(TK_SQ);
      CL_LP:     a = em(TK_LP);
      CL_RP:     a = em(TK_RP);
      CL_LT:     a = go(ST_LT);
      CL_GT:     a = go(ST_GT);
      CL_EQ:     a = em(TK_EQ);
      default:   a = em(TK_ERR);
    endcase
    return a;
  endfunction

  function automatic action_t dfa_action(input logic [4:0] s, input logic [4:0] cl);
    action_t a;
    case (s)
      ST_START: a = start_row(cl);
      ST_PLUS, ST_MINUS: begin
        if (cl == CL_DOT) a = go(ST_DOT);
        else if (cl == CL_DIGIT) a = go(ST_INT);
        else a = pb((s == ST_PLUS) ? TK_PLUS : TK_MINUS);
      end
      ST_INT: begin
        if (cl == CL_DOT) a = go(ST_FRAC);
        else if (cl == CL_SLASH) a = go(ST_SLASH);
        else if (cl == CL_DIGIT) a = go(ST_INT);
        else a = pb(TK_NUM);
      end
      ST_DOT:   a = (cl == CL_DIGIT) ? go(ST_FRAC) : em(TK_ERR);
      ST_FRAC:  a = (cl == CL_DIGIT) ? go(ST_FRAC) : pb(TK_NUM);
      ST_SLASH: a = (cl == CL_DIGIT) ? go(ST_RAT) : em(TK_ERR);
      ST_RAT:   a = (cl == CL_DIGIT) ? go(ST_RAT) : pb(TK_NUM);
      ST_WORD, ST_C, ST_CA, ST_CD, ST_CAD, ST_CDA: a = word_row(s, cl);
      ST_STR:   a = (cl == CL_DQUOTE) ? em(TK_STR) : go(ST_STR);
      ST_GT:    a = (cl == CL_EQ) ? em(TK_GTE) : pb(TK_GT);
      ST_LT:    a = (cl == CL_EQ) ? em(TK_LTE) : pb(TK_LT);
      default:  a = em(TK_ERR);
    endcase
    return a;
  endfunction

  // Keyword text padded with spaces to KW_MAX_LEN; kind is TK_KW + index
  function automatic kw_t kw_entry(input int i);
    kw_t k;
    case (i)
      0:       k = '{text: "cons   ", len: 3'd4, q: 1'b0};
      1:       k = '{text: "cond   ", len: 3'd4, q: 1'b0};
      2:       k = '{text: "else   ", len: 3'd4, q: 1'b0};
      3:       k = '{text: "display", len: 3'd7, q: 1'b0};
      4:       k = '{text: "newline", len: 3'd7, q: 1'b0};
      5:       k = '{text: "and    ", len: 3'd3, q: 1'b0};
      6:       k = '{text: "or     ", len: 3'd2, q: 1'b0};
      7:       k = '{text: "not    ", len: 3'd3, q: 1'b0};
      8:       k = '{text: "define ", len: 3'd6, q: 1'b0};
      9:       k = '{text: "let    ", len: 3'd3, q: 1'b0};
      10:      k = '{text: "number ", len: 3'd6, q: 1'b1};
      11:      k = '{text: "list   ", len: 3'd4, q: 1'b1};
      12:      k = '{text: "zero   ", len: 3'd4, q: 1'b1};
      13:      k = '{text: "null   ", len: 3'd4, q: 1'b1};
      14:      k = '{text: "string ", len: 3'd6, q: 1'b1};
      15:      k = '{text: "modulo ", len: 3'd6, q: 1'b0};
      16:      k = '{text: "round  ", len: 3'd5, q: 1'b0};
      default: k = '{text: "       ", len: 3'd0, q: 1'b0};
    endcase
    return k;
  endfunction

endpackage

/* src/dts_kw_match.sv */
// Parallel compare of the buffered identifier against the keyword list.
module dts_kw_match #(
  parameter int WORD_CHARS = dts_pkg::WORD_CHARS_DEF
) (
  input  logic [6:0]                       word_buf [WORD_CHARS],
  input  logic [$clog2(WORD_CHARS+1)-1:0]  word_len,
  input  logic                             word_ovf,
  output dts_pkg::kw_result_t              result
);
  import dts_pkg::*;

  localparam int LEN_W = $clog2(WORD_CHARS + 1);

  always_comb begin
    kw_t        k;
    logic       hit;
    logic [6:0] ch;
    result = '0;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      k   = kw_entry(i);
      hit = !word_ovf && (word_len == LEN_W'(k.len));
      for (int j = 0; j < KW_MAX_LEN; j++) begin
        ch = k.text[8*(KW_MAX_LEN-1-j) +: 7];
        if ((j < int'(k.len)) && (word_buf[j] != ch)) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        if (k.q) begin
          result.q_hit  = 1'b1;
          result.q_kind = TK_KW + 6'(i);
        end else begin
          result.plain_hit  = 1'b1;
          result.plain_kind = TK_KW + 6'(i);
        end
      end
    end
  end

endmodule

/* src/dts_result_queue.sv */
// Small result queue that takes up to two tokens a cycle and hands out one.
module dts_result_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  dts_pkg::push_t      push,
  output logic                room_two,
  output logic                out_valid,
  input  logic                out_ready,
  output dts_pkg::token_t     out_token
);
  import dts_pkg::*;

  token_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                pop;

  assign pop       = (count_r != '0) && out_ready;
  assign out_valid = (count_r != '0);
  assign out_token = mem[rd_ptr_r];
  assign room_two  = (count_r <= QCNT_W'(QUEUE_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.n);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    count_nxt  = count_r + QCNT_W'(push.n) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr_r] <= push.t0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr_r + QPTR_W'(1)] <= push.t1;
    end
  end

endmodule

/* src/dfa_token_scanner.sv */
// DFA token scanner top level: scan state, identifier buffer and step logic.
//
// Usage: one character (or an end marker) enters per item on the in_ channel
// (valid/ready). Each item is classified and steps the 18-state table in the
// same cycle it is accepted; the resulting tokens (zero, one or two) go into
// a four-entry result queue that drives the out_ channel (valid/ready).
// out_last_of_run marks the final token caused by an item.
// Tokens are written into the registered result queue and leave it in order on out_.
// Throughput: one item per cycle while the queue holds at most two tokens;
// an item that gives two tokens is accepted like any other, the queue absorbs
// the extra token and drains one per cycle while out_ready is high.
// End marker: a pending token is flushed, eof follows, scanner returns to
// the start state.
// Reset: the scanner sits in the start state with an empty queue; buffer
// contents are not cleared.
// Stall: when out_ready is low the queue fills and in_ready drops once
// fewer than two entries are free; nothing is lost or repeated.
module dfa_token_scanner #(
  parameter int WORD_CHARS = dts_pkg::WORD_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [6:0] in_char_code,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] out_token_kind,
  output logic       out_last_of_run
);
  import dts_pkg::*;

  localparam int LEN_W = $clog2(WORD_CHARS + 1);
  localparam int IDX_W = $clog2(WORD_CHARS);

  logic [4:0]       scan_state_r, scan_state_nxt;
  logic [LEN_W-1:0] word_len_r, word_len_nxt;
  logic             word_ovf_r, word_ovf_nxt;
  logic [6:0]       word_buf_r [WORD_CHARS];
  logic             buf_we;
  logic [IDX_W-1:0] buf_idx;

  kw_result_t       kw;
  push_t            push;
  token_t           q_token;
  logic             room_two;
  logic             accept;
  logic [4:0]       cls;
  action_t          act, act2;
  logic [5:0]       word_kind;
  logic [LEN_W-1:0] base_len;
  logic             base_ovf;

  assign in_ready = room_two;
  assign accept   = in_valid && in_ready;
  assign cls      = char_class(in_char_code);
  assign act      = dfa_action(scan_state_r, in_end_of_text ? CL_WS : cls);
  assign act2     = dfa_action(ST_START, cls);
  assign word_kind = kw.plain_hit ? kw.plain_kind : TK_IDENT;

  dts_kw_match #(.WORD_CHARS(WORD_CHARS)) u_kw (
    .word_buf (word_buf_r),
    .word_len (word_len_r),
    .word_ovf (word_ovf_r),
    .result   (kw)
  );

  always_comb begin
    scan_state_nxt = scan_state_r;
    word_len_nxt   = word_len_r;
    word_ovf_nxt   = word_ovf_r;
    buf_we         = 1'b0;
    buf_idx        = '0;
    push           = '0;
    base_len       = is_word_state(scan_state_r) ? word_len_r : '0;
    base_ovf       = is_word_state(scan_state_r) ? word_ovf_r : 1'b0;
    if (accept) begin
      if (in_end_of_text) begin
        if (scan_state_r != ST_START) begin
          push.n = 2'd2;
          if (act[7:6] == 2'b00) begin
            push.t0.kind = TK_ERR;
          end else if (act[7] && (act[5:0] == TK_IDENT)) begin
            push.t0.kind = word_kind;
          end else begin
            push.t0.kind = act[5:0];
          end
          push.t1 = '{kind: TK_EOF, last: 1'b1};
        end else begin
          push.n  = 2'd1;
          push.t0 = '{kind: TK_EOF, last: 1'b1};
        end
        scan_state_nxt = ST_START;
        word_len_nxt   = '0;
        word_ovf_nxt   = 1'b0;
      end else if (act[7:6] == 2'b00) begin
        scan_state_nxt = act[4:0];
        if (is_word_state(act[4:0])) begin
          if (base_len < LEN_W'(WORD_CHARS)) begin
            buf_we       = 1'b1;
            buf_idx      = base_len[IDX_W-1:0];
            word_len_nxt = base_len + LEN_W'(1);
            word_ovf_nxt = base_ovf;
          end else begin
            word_len_nxt = base_len;
            word_ovf_nxt = 1'b1;
          end
        end
      end else if (act[6]) begin
        push.n         = 2'd1;
        push.t0        = '{kind: act[5:0], last: 1'b1};
        scan_state_nxt = ST_START;
      end else if ((act[5:0] == TK_IDENT) && (in_char_code == CH_QMARK) && kw.q_hit) begin
        // predicate keyword absorbs its question mark
        push.n         = 2'd1;
        push.t0        = '{kind: kw.q_kind, last: 1'b1};
        scan_state_nxt = ST_START;
      end else begin
        // token ended by lookahead; rescan the character from start
        push.t0.kind = (act[5:0] == TK_IDENT) ? word_kind : act[5:0];
        if (act2[7:6] == 2'b00) begin
          push.n         = 2'd1;
          push.t0.last   = 1'b1;
          scan_state_nxt = act2[4:0];
          if (is_word_state(act2[4:0])) begin
            buf_we       = 1'b1;
            buf_idx      = '0;
            word_len_nxt = LEN_W'(1);
            word_ovf_nxt = 1'b0;
          end
        end else begin
          push.n         = 2'd2;
          push.t1        = '{kind: act2[5:0], last: 1'b1};
          scan_state_nxt = ST_START;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_state_r <= ST_START;
      word_len_r   <= '0;
      word_ovf_r   <= 1'b0;
    end else begin
      scan_state_r <= scan_state_nxt;
      word_len_r   <= word_len_nxt;
      word_ovf_r   <= word_ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      word_buf_r[buf_idx] <= in_char_code;
    end
  end

  dts_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room_two  (room_two),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_token (q_token)
  );

  assign out_token_kind  = q_token.kind;
  assign out_last_of_run = q_token.last;

endmodule

/* test/dts_token_checker.sv */
// Token checker for the DFA token scanner: predicts tokens from accepted items and compares.
`timescale 1ns / 100ps
module dts_token_checker #(
  parameter int WORD_CHARS = dts_pkg::WORD_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [6:0] in_char_code,
  input  logic       in_end_of_text,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [5:0] out_token_kind,
  input  logic       out_last_of_run,
  output int         fail_count,
  output int         pending,
  output int         tokens_seen
);
  import dts_pkg::*;

  localparam int KW_NUM = 17;
  // keywords that take a trailing '?'
  localparam bit [KW_NUM-1:0] KW_WITH_Q = 17'b0_0111_1100_0000_0000;

  typedef struct packed {
    logic       take;   // a token is produced
    logic       again;  // the item is rescanned from start
    logic [5:0] kind;
    logic [4:0] nxt;
  } step_t;

  string kw_text [KW_NUM] = '{"cons", "cond", "else", "display", "newline", "and", "or",
                              "not", "define", "let", "number", "list", "zero", "null",
                              "string", "modulo", "round"};

  logic [4:0] scan_st = ST_START;
  logic [6:0] word_buf [WORD_CHARS];
  int         word_len = 0;
  logic       word_ovf = 1'b0;
  logic [5:0] step_toks [$];
  logic [5:0] want_kind [$];
  logic       want_last [$];
  logic [5:0] exp_kind;
  logic       exp_last;
  int         fails = 0;
  int         seen = 0;

  function automatic step_t go_to(input logic [4:0] s);
    return '{take: 1'b0, again: 1'b0, kind: 6'd0, nxt: s};
  endfunction

  function automatic step_t give(input logic [5:0] k);
    return '{take: 1'b1, again: 1'b0, kind: k, nxt: ST_START};
  endfunction

  function automatic step_t give_back(input logic [5:0] k);
    return '{take: 1'b1, again: 1'b1, kind: k, nxt: ST_START};
  endfunction

  function automatic logic [4:0] char_group(input logic [6:0] c);
    logic [7:0] b;
    b = {1'b0, c};
    if (b == 8'h09 || b == 8'h0a || b == 8'h0d || b == 8'h20) return CL_WS;
    if (b == "c") return CL_C;
    if (b == "a") return CL_A;
    if (b == "d") return CL_D;
    if (b == "r") return CL_R;
    if (b >= "a" && b <= "z") return CL_LETTER;
    if (b >= "0" && b <= "9") return CL_DIGIT;
    case (b)
      "+": return CL_PLUS;
      "-": return CL_MINUS;
      ".": return CL_DOT;
      "/": return CL_SLASH;
      "*": return CL_STAR;
      "\"": return CL_DQUOTE;
      "'": return CL_SQUOTE;
      "(": return CL_LP;
      ")": return CL_RP;
      "<": return CL_LT;
      ">": return CL_GT;
      "=": return CL_EQ;
      "_": return CL_UNDER;
      default: return CL_OTHER;
    endcase
  endfunction

  function automatic bit wordy(input logic [4:0] s);
    return s == ST_WORD || (s >= ST_C && s <= ST_CDA);
  endfunction

  function automatic step_t dfa_step(input logic [4:0] s, input logic [4:0] g);
    step_t a;
    a = give(TK_ERR);
    case (s)
      ST_START: begin
        case (g)
          CL_WS:                                 a = go_to(ST_START);
          CL_LETTER, CL_A, CL_D, CL_R, CL_UNDER: a = go_to(ST_WORD);
          CL_C:                                  a = go_to(ST_C);
          CL_PLUS:                               a = go_to(ST_PLUS);
          CL_MINUS:                              a = go_to(ST_MINUS);
          CL_DOT:                                a = go_to(ST_DOT);
          CL_SLASH:                              a = give(TK_DIV);
          CL_DIGIT:                              a = go_to(ST_INT);
          CL_STAR:                               a = give(TK_MULT);
          CL_DQUOTE:                             a = go_to(ST_STR);
          CL_SQUOTE:                             a = give(TK_SQ);
          CL_LP:                                 a = give(TK_LP);
          CL_RP:                                 a = give(TK_RP);
          CL_LT:                                 a = go_to(ST_LT);
          CL_GT:                                 a = go_to(ST_GT);
          CL_EQ:                                 a = give(TK_EQ);
          default:                               a = give(TK_ERR);
        endcase
      end
      ST_PLUS, ST_MINUS: begin
        if (g == CL_DOT) a = go_to(ST_DOT);
        else if (g == CL_DIGIT) a = go_to(ST_INT);
        else a = give_back(s == ST_PLUS ? TK_PLUS : TK_MINUS);
      end
      ST_INT: begin
        // dot after digits goes straight to the fraction state
        if (g == CL_DOT) a = go_to(ST_FRAC);
        else if (g == CL_SLASH) a = go_to(ST_SLASH);
        else if (g == CL_DIGIT) a = go_to(ST_INT);
        else a = give_back(TK_NUM);
      end
      ST_DOT:   a = (g == CL_DIGIT) ? go_to(ST_FRAC) : give(TK_ERR);
      ST_FRAC:  a = (g == CL_DIGIT) ? go_to(ST_FRAC) : give_back(TK_NUM);
      ST_SLASH: a = (g == CL_DIGIT) ? go_to(ST_RAT) : give(TK_ERR);
      ST_RAT:   a = (g == CL_DIGIT) ? go_to(ST_RAT) : give_back(TK_NUM);
      ST_STR:   a = (g == CL_DQUOTE) ? give(TK_STR) : go_to(ST_STR);
      ST_GT:    a = (g == CL_EQ) ? give(TK_GTE) : give_back(TK_GT);
      ST_LT:    a = (g == CL_EQ) ? give(TK_LTE) : give_back(TK_LT);
      ST_WORD, ST_C, ST_CA, ST_CD, ST_CAD, ST_CDA: begin
        case (g)
          CL_LETTER, CL_C, CL_DIGIT, CL_UNDER: a = go_to(ST_WORD);
          CL_A: a = go_to(s == ST_C ? ST_CA : (s == ST_CD ? ST_CDA : ST_WORD));
          CL_D: a = go_to((s == ST_C || s == ST_CD) ? ST_CD :
                          ((s == ST_CA || s == ST_CAD) ? ST_CAD : ST_WORD));
          CL_R: a = (s >= ST_CA && s <= ST_CDA) ? give(TK_LISTOP) : go_to(ST_WORD);
          default: a = give_back(TK_IDENT);
        endcase
      end
      default: a = give(TK_ERR);
    endcase
    return a;
  endfunction

  function automatic int kw_lookup(input bit with_q);
    int hit;
    bit same;
    hit = -1;
    if (!word_ovf) begin
      for (int i = 0; i < KW_NUM; i++) begin
        if (hit < 0 && KW_WITH_Q[i] == with_q && kw_text[i].len() == word_len) begin
          same = 1'b1;
          for (int j = 0; j < word_len; j++) begin
            if (kw_text[i][j] != {1'b0, word_buf[j]}) same = 1'b0;
          end
          if (same) hit = TK_KW + i;
        end
      end
    end
    return hit;
  endfunction

  function automatic logic [5:0] word_kind();
    int k;
    k = kw_lookup(1'b0);
    return (k < 0) ? TK_IDENT : 6'(k);
  endfunction

  // one pass of a character; returns 1 when it must be rescanned from start
  function automatic bit lex_char(input logic [6:0] c);
    step_t a;
    int q;
    a = dfa_step(scan_st, char_group(c));
    if (!a.take) begin
      if (wordy(a.nxt)) begin
        if (!wordy(scan_st)) begin
          word_len = 0;
          word_ovf = 1'b0;
        end
        if (word_len < WORD_CHARS) begin
          word_buf[word_len] = c;
          word_len++;
        end else begin
          word_ovf = 1'b1;
        end
      end
      scan_st = a.nxt;
      return 1'b0;
    end
    scan_st = ST_START;
    if (!a.again) begin
      step_toks.push_back(a.kind);
      return 1'b0;
    end
    if (a.kind == TK_IDENT) begin
      q = kw_lookup(1'b1);
      if (c == CH_QMARK && q >= 0) begin
        step_toks.push_back(6'(q));
        return 1'b0;
      end
      step_toks.push_back(word_kind());
    end else begin
      step_toks.push_back(a.kind);
    end
    return 1'b1;
  endfunction

  task automatic predict(input logic [6:0] c, input logic eot);
    step_t a;
    step_toks.delete();
    if (eot) begin
      if (scan_st != ST_START) begin
        a = dfa_step(scan_st, CL_WS);
        if (!a.take) step_toks.push_back(TK_ERR);
        else if (a.again && a.kind == TK_IDENT) step_toks.push_back(word_kind());
        else step_toks.push_back(a.kind);
      end
      step_toks.push_back(TK_EOF);
      scan_st = ST_START;
      word_len = 0;
      word_ovf = 1'b0;
    end else if (lex_char(c)) begin
      void'(lex_char(c));
    end
    foreach (step_toks[i]) begin
      want_kind.push_back(step_toks[i]);
      want_last.push_back(i == step_toks.size() - 1);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      scan_st = ST_START;
      word_len = 0;
      word_ovf = 1'b0;
      want_kind.delete();
      want_last.delete();
    end else begin
      if (in_valid && in_ready) predict(in_char_code, in_end_of_text);
      if (out_valid && out_ready) begin
        seen++;
        if (want_kind.size() == 0) begin
          $error("token_kind: expected none, got %0d", out_token_kind);
          fails++;
        end else begin
          exp_kind = want_kind.pop_front();
          exp_last = want_last.pop_front();
          if (out_token_kind !== exp_kind) begin
            $error("token_kind: expected %0d, got %0d", exp_kind, out_token_kind);
            fails++;
          end
          if (out_last_of_run !== exp_last) begin
            $error("last_of_run: expected %0d, got %0d", exp_last, out_last_of_run);
            fails++;
          end
        end
      end
    end
    fail_count <= fails;
    pending <= want_kind.size();
    tokens_seen <= seen;
  end

endmodule

/* test/dfa_token_scanner_tb.sv */
// Testbench top for the DFA token scanner: character stimulus, idling phases and verdict.
`timescale 1ns / 100ps
module dfa_token_scanner_tb;

  localparam int PHASES          = 4;
  localparam int ITEMS_PER_PHASE = 300;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [6:0] in_char_code = 7'd0;
  logic       in_end_of_text = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [5:0] out_token_kind;
  logic       out_last_of_run;

  int fail_count;
  int pending;
  int tokens_seen;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int texts_sent = 0;

  string kw_text [17] = '{"cons", "cond", "else", "display", "newline", "and", "or",
                          "not", "define", "let", "number", "list", "zero", "null",
                          "string", "modulo", "round"};
  string op_chars = "+-/*='()<>";

  dfa_token_scanner dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_code   (in_char_code),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_token_kind (out_token_kind),
    .out_last_of_run(out_last_of_run)
  );

  dts_token_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_code   (in_char_code),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_token_kind (out_token_kind),
    .out_last_of_run(out_last_of_run),
    .fail_count     (fail_count),
    .pending        (pending),
    .tokens_seen    (tokens_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send_char(input logic [6:0] c, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= c;
    in_end_of_text <= eot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(7'(s[i]), 1'b0);
  endtask

  task automatic send_end();
    send_char(7'($urandom_range(127)), 1'b1);
    texts_sent++;
  endtask

  // hold the sender off until every expected token has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [6:0] blank();
    case ($urandom_range(3))
      0: return 7'h09;
      1: return 7'h0a;
      2: return 7'h0d;
      default: return 7'h20;
    endcase
  endfunction

  function automatic logic [6:0] digit();
    return 7'(8'h30 + $urandom_range(9));
  endfunction

  function automatic logic [6:0] word_char();
    case ($urandom_range(9))
      0: return digit();
      1: return 7'("_");
      default: return 7'(8'h61 + $urandom_range(25));
    endcase
  endfunction

  task automatic gen_token();
    logic [6:0] ch;
    case ($urandom_range(11))
      0, 1: begin
        send_text(kw_text[$urandom_range(16)]);
        if ($urandom_range(1)) send_char(7'("?"), 1'b0);
      end
      2: begin
        send_char(7'("c"), 1'b0);
        repeat ($urandom_range(4)) send_char(7'($urandom_range(1) ? "a" : "d"), 1'b0);
        if ($urandom_range(3) != 0) send_char(7'("r"), 1'b0);
      end
      3, 4: begin
        send_char($urandom_range(7) == 0 ? 7'("_") : 7'(8'h61 + $urandom_range(25)), 1'b0);
        repeat ($urandom_range(11)) send_char(word_char(), 1'b0);
        if ($urandom_range(4) == 0) send_char(7'("?"), 1'b0);
      end
      5, 6: begin
        if ($urandom_range(9) < 3) send_char(7'($urandom_range(1) ? "+" : "-"), 1'b0);
        repeat ($urandom_range(4)) send_char(digit(), 1'b0);
        case ($urandom_range(4))
          0: begin
            send_char(7'("."), 1'b0);
            repeat ($urandom_range(3)) send_char(digit(), 1'b0);
          end
          1: begin
            send_char(7'("/"), 1'b0);
            repeat ($urandom_range(3)) send_char(digit(), 1'b0);
          end
          default: ;
        endcase
      end
      7: begin
        send_char(7'("\""), 1'b0);
        repeat ($urandom_range(6)) begin
          do ch = 7'($urandom_range(32, 126)); while (ch == 7'("\""));
          send_char(ch, 1'b0);
        end
        if ($urandom_range(6) != 0) send_char(7'("\""), 1'b0);
      end
      8, 9: begin
        ch = 7'(op_chars[$urandom_range(op_chars.len() - 1)]);
        send_char(ch, 1'b0);
        if ((ch == 7'("<") || ch == 7'(">")) && $urandom_range(1)) send_char(7'("="), 1'b0);
      end
      10: repeat ($urandom_range(1, 3)) send_char(7'($urandom_range(127)), 1'b0);
      default: repeat ($urandom_range(1, 4)) send_char(blank(), 1'b0);
    endcase
    if ($urandom_range(9) < 6) send_char(blank(), 1'b0);
  endtask

  initial begin
    int goal;
    int toks_left;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: code extremes, less/greater, bad numbers, '?' cases, open string
    send_char(7'h00, 1'b0);
    send_char(7'h7f, 1'b0);
    send_text("<=>a?. 5/)zero?1. \"");
    send_end();
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 84;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 84;
        end
        default: begin
          send_idle_pct = 35;
          stall_pct = 35;
        end
      endcase
      goal = items_sent + ITEMS_PER_PHASE;
      toks_left = $urandom_range(8, 40);
      while (items_sent < goal) begin
        gen_token();
        toks_left--;
        if (toks_left == 0) begin
          send_end();
          toks_left = $urandom_range(8, 40);
        end
      end
      send_end();
      drain();
    end

    repeat (20) @(posedge clk);
    $display("sent %0d items in %0d texts, %0d tokens compared", items_sent, texts_sent,
             tokens_seen);
    $display("idling: none, sender 84%%, receiver 84%%, both 35%%");
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* sim.f */
src/dts_pkg.sv
src/dts_kw_match.sv
src/dts_result_queue.sv
src/dfa_token_scanner.sv
test/dts_token_checker.sv
test/dfa_token_scanner_tb.sv
